[hdl/efla_pkg.sv]
// Shared types, constants and tag helper for the free list heap allocator.
// No dependencies; imported by efla_seq and the top level.
`timescale 1ns / 1ps
package efla_pkg;

  localparam logic       OP_ALLOC   = 1'b0;
  localparam logic       OP_RELEASE = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ZERO    = 2'd1;
  localparam logic [1:0] ST_OOM     = 2'd2;
  localparam logic [1:0] ST_NULL    = 2'd3;

  localparam logic [31:0] MIN_BLOCK = 32'd24;
  localparam logic [31:0] SIZE_MASK = 32'hFFFF_FFF8;
  localparam logic [31:0] PA_BIT    = 32'h0000_0002;

  // result handed from the sequencer to the output register
  typedef struct packed {
    logic        valid;
    logic [15:0] block_addr;
    logic [1:0]  status;
  } res_t;

  // boundary tag: size | prev-allocated << 1 | allocated
  function automatic logic [31:0] tag(input logic [31:0] size, input logic pa,
                                      input logic a);
    tag = size | {30'b0, pa, 1'b0} | {31'b0, a};
  endfunction

endpackage

[hdl/efla_ram.sv]
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module efla_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[hdl/efla_seq.sv]
// Allocator sequencer: walks the heap through one RAM port, one access a cycle.
// Depends on efla_pkg; drives the port of an efla_ram instance.
`timescale 1ns / 1ps
module efla_seq import efla_pkg::*; #(
  parameter int HEAP_BYTES = 65536,
  parameter int GROW_BYTES = 4096,
  localparam int MEM_WORDS = HEAP_BYTES / 4,
  localparam int AW        = $clog2(MEM_WORDS),
  localparam int BRK_W     = $clog2(HEAP_BYTES) + 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_op,
  input  logic [15:0]   in_request_bytes,
  input  logic [15:0]   in_release_addr,
  output res_t          res,
  input  logic          res_take,
  output logic          mem_we,
  output logic [AW-1:0] mem_addr,
  output logic [31:0]   mem_wdata,
  input  logic [31:0]   mem_rdata
);

  localparam logic [31:0] HEAP_LIM = 32'(HEAP_BYTES);
  localparam logic [16:0] GROW_L   = 17'(GROW_BYTES);
  localparam logic [14:0] INIT_WDS = 15'(GROW_BYTES / 4);
  localparam logic [AW:0] WALK_MAX = (AW + 1)'(MEM_WORDS);

  typedef enum logic [5:0] {
    S_IDLE, S_BLD0, S_BLD1, S_BLD2, S_BLD3, S_ACHK, S_FF0, S_FF1, S_FF2, S_AGR,
    S_T0, S_T1, S_T2, S_T3, S_T4, S_T5, S_TOK,
    S_REL0, S_REL1, S_REL2, S_REL3, S_REL4, S_REL5, S_REL6,
    S_G0, S_G1, S_G2, S_G3, S_G4, S_G5, S_G6, S_G7,
    S_LK0, S_LK1, S_LK2, S_UL0, S_UL1, S_UL2, S_UL3,
    S_M0, S_M1, S_M2, S_MP1, S_MP2, S_M3, S_M4, S_M5, S_M6,
    S_MA1, S_MA2, S_MA3, S_MA4, S_MA5, S_MB0, S_MB1, S_DONE
  } state_t;

  state_t state_r, gr_ret_r, lk_ret_r, ul_ret_r, mg_ret_r;

  logic [BRK_W-1:0] brk_r;
  logic [31:0]      head_r;
  logic             ready_r;

  logic [15:0] req_r;
  logic [31:0] ptr_r;
  logic [16:0] need_r;
  logic [15:0] addr_r;
  logic [1:0]  status_r;
  logic [AW:0] ff_n_r;
  logic [31:0] ff_bp_r, tk_bp_r, cs_r, aft_r, sz_r;
  logic        split_r;
  logic [17:0] g_sz_r;
  logic [31:0] g_bp_r, gres_r;
  logic [31:0] lk_x_r, ul_x_r, nx_r, pv_r;
  logic [31:0] mg_bp_r, mres_r, hsz_r, nsz_r, msz_r, bef_r;
  logic        mpa_r, na_r, pp_r;

  logic [31:0] rd_sz;
  logic [31:0] g_sz32;
  logic [16:0] need_c, ext_c;

  assign rd_sz  = mem_rdata & SIZE_MASK;
  assign g_sz32 = 32'(g_sz_r);
  assign need_c = (in_request_bytes <= 16'd16) ? 17'd24 :
                  ((17'(in_request_bytes) + 17'd15) & ~17'd7);
  assign ext_c  = (need_r > GROW_L) ? need_r : GROW_L;

  function automatic logic [AW-1:0] widx(input logic [31:0] a);
    widx = a[AW+1:2];
  endfunction

  // even number of words, at least one minimum block
  function automatic logic [17:0] grow_size(input logic [14:0] words);
    logic [15:0] ev;
    logic [17:0] sz;
    ev = {1'b0, words} + {15'b0, words[0]};
    sz = {ev, 2'b00};
    grow_size = (sz < 18'd24) ? 18'd24 : sz;
  endfunction

  assign in_ready         = (state_r == S_IDLE);
  assign res.valid        = (state_r == S_DONE);
  assign res.block_addr   = addr_r;
  assign res.status       = status_r;

  // memory port
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = '0;
    mem_wdata = '0;
    unique case (state_r)
      S_BLD0: begin mem_we = 1'b1; mem_addr = widx(32'd0);  mem_wdata = 32'd0; end
      S_BLD1: begin mem_we = 1'b1; mem_addr = widx(32'd4);  mem_wdata = tag(32'd8, 1'b1, 1'b1); end
      S_BLD2: begin mem_we = 1'b1; mem_addr = widx(32'd8);  mem_wdata = tag(32'd8, 1'b0, 1'b1); end
      S_BLD3: begin mem_we = 1'b1; mem_addr = widx(32'd12); mem_wdata = tag(32'd0, 1'b1, 1'b1); end
      S_FF0:  mem_addr = widx(ff_bp_r - 32'd4);
      S_FF1:  mem_addr = widx(ff_bp_r + 32'd8);
      S_T0:   mem_addr = widx(tk_bp_r - 32'd4);
      S_T1: begin
        mem_we    = 1'b1;
        mem_addr  = widx(tk_bp_r - 32'd4);
        mem_wdata = ((rd_sz - 32'(need_r)) >= MIN_BLOCK) ?
                    tag(32'(need_r), mem_rdata[1], 1'b1) : tag(rd_sz, mem_rdata[1], 1'b1);
      end
      S_T2: begin
        if (split_r) begin
          mem_we    = 1'b1;
          mem_addr  = widx(tk_bp_r + 32'(need_r) - 32'd4);
          mem_wdata = tag(cs_r - 32'(need_r), 1'b1, 1'b0);
        end else begin
          mem_addr  = widx(tk_bp_r - 32'd4);
        end
      end
      S_T3: begin
        mem_we = 1'b1; mem_addr = widx(tk_bp_r + cs_r - 32'd8);
        mem_wdata = cs_r - 32'(need_r);
      end
      S_T4:   mem_addr = widx(tk_bp_r + rd_sz - 32'd4);
      S_T5: begin mem_we = 1'b1; mem_addr = widx(aft_r - 32'd4); mem_wdata = mem_rdata | PA_BIT; end
      S_REL0: mem_addr = widx(ptr_r - 32'd4);
      S_REL1: begin
        mem_we = 1'b1; mem_addr = widx(ptr_r - 32'd4);
        mem_wdata = tag(rd_sz, mem_rdata[1], 1'b0);
      end
      S_REL2: begin mem_we = 1'b1; mem_addr = widx(ptr_r + sz_r - 32'd8); mem_wdata = sz_r; end
      S_REL3: mem_addr = widx(ptr_r - 32'd4);
      S_REL4: mem_addr = widx(ptr_r + rd_sz - 32'd4);
      S_REL5: begin mem_we = 1'b1; mem_addr = widx(aft_r - 32'd4); mem_wdata = mem_rdata & ~PA_BIT; end
      S_G0:   mem_addr = widx(32'(brk_r) - 32'd4);
      S_G1: begin
        mem_we = 1'b1; mem_addr = widx(g_bp_r - 32'd4);
        mem_wdata = tag(g_sz32, mem_rdata[1], 1'b0);
      end
      S_G2: begin mem_we = 1'b1; mem_addr = widx(g_bp_r + g_sz32 - 32'd8); mem_wdata = g_sz32; end
      S_G3: begin mem_we = 1'b1; mem_addr = widx(g_bp_r + 32'd8); mem_wdata = 32'd0; end
      S_G4: begin mem_we = 1'b1; mem_addr = widx(g_bp_r); mem_wdata = 32'd0; end
      S_G5: begin
        mem_we = 1'b1; mem_addr = widx(g_bp_r + g_sz32 - 32'd4);
        mem_wdata = tag(32'd0, 1'b0, 1'b1);
      end
      S_LK0: begin
        mem_we = (lk_x_r != 32'd0) && (head_r != 32'd0);
        mem_addr = widx(head_r); mem_wdata = lk_x_r;
      end
      S_LK1: begin mem_we = 1'b1; mem_addr = widx(lk_x_r + 32'd8); mem_wdata = head_r; end
      S_LK2: begin mem_we = 1'b1; mem_addr = widx(lk_x_r); mem_wdata = 32'd0; end
      S_UL0:  mem_addr = widx(ul_x_r + 32'd8);
      S_UL1:  mem_addr = widx(ul_x_r);
      S_UL2: begin mem_we = (nx_r != 32'd0); mem_addr = widx(nx_r); mem_wdata = mem_rdata; end
      S_UL3: begin mem_we = (pv_r != 32'd0); mem_addr = widx(pv_r + 32'd8); mem_wdata = nx_r; end
      S_M0:   mem_addr = widx(mg_bp_r - 32'd4);
      S_M1:   mem_addr = widx(mg_bp_r + rd_sz - 32'd4);
      S_M2:   mem_addr = widx(mg_bp_r - 32'd8);
      S_MP1: begin mem_we = 1'b1; mem_addr = widx(mg_bp_r - 32'd4); mem_wdata = tag(msz_r, 1'b1, 1'b0); end
      S_MP2: begin mem_we = 1'b1; mem_addr = widx(mg_bp_r + msz_r - 32'd8); mem_wdata = msz_r; end
      S_M3:   mem_addr = widx(mg_bp_r - rd_sz - 32'd4);
      S_M4: begin
        mem_we = 1'b1;
        if (na_r) begin
          mem_addr = widx(mg_bp_r + hsz_r - 32'd8); mem_wdata = hsz_r + rd_sz;
        end else begin
          mem_addr = widx(bef_r - 32'd4);
          mem_wdata = tag(hsz_r + rd_sz + nsz_r, mem_rdata[1], 1'b0);
        end
      end
      S_M5:   mem_addr = widx(mg_bp_r - 32'd8);
      S_M6: begin
        mem_we = 1'b1; mem_addr = widx(mg_bp_r - rd_sz - 32'd4);
        mem_wdata = tag(msz_r, pp_r, 1'b0);
      end
      S_MA1:  mem_addr = widx(mg_bp_r - 32'd4);
      S_MA2:  mem_addr = widx(mg_bp_r + rd_sz - 32'd4);
      S_MA3: begin mem_we = 1'b1; mem_addr = widx(aft_r + rd_sz - 32'd8); mem_wdata = msz_r; end
      S_MA4:  mem_addr = widx(mg_bp_r - 32'd4);
      S_MB0:  mem_addr = widx(mg_bp_r - 32'd8);
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      brk_r   <= '0;
      head_r  <= '0;
      ready_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            req_r    <= in_request_bytes;
            need_r   <= need_c;
            ptr_r    <= {16'b0, in_release_addr};
            addr_r   <= '0;
            status_r <= ST_OK;
            if (in_op == OP_ALLOC) begin
              state_r <= ready_r ? S_ACHK : S_BLD0;
            end else if (in_release_addr == 16'd0) begin
              status_r <= ST_NULL;
              state_r  <= S_DONE;
            end else begin
              state_r <= S_REL0;
            end
          end
        end
        S_BLD0: begin head_r <= '0; brk_r <= BRK_W'(16); state_r <= S_BLD1; end
        S_BLD1: state_r <= S_BLD2;
        S_BLD2: state_r <= S_BLD3;
        S_BLD3: begin
          ready_r  <= 1'b1;
          g_sz_r   <= grow_size(INIT_WDS);
          gr_ret_r <= S_ACHK;
          state_r  <= S_G0;
        end
        S_ACHK: begin
          if (req_r == 16'd0) begin
            status_r <= ST_ZERO;
            state_r  <= S_DONE;
          end else begin
            ff_bp_r <= head_r;
            ff_n_r  <= '0;
            state_r <= S_FF0;
          end
        end
        S_FF0: begin
          if ((ff_n_r < WALK_MAX) && (ff_bp_r != 32'd0)) begin
            state_r <= S_FF1;
          end else begin
            g_sz_r   <= grow_size(ext_c[16:2]);
            gr_ret_r <= S_AGR;
            state_r  <= S_G0;
          end
        end
        S_FF1: begin
          if (32'(need_r) <= rd_sz) begin
            tk_bp_r <= ff_bp_r;
            state_r <= S_T0;
          end else begin
            state_r <= S_FF2;
          end
        end
        S_FF2: begin ff_bp_r <= mem_rdata; ff_n_r <= ff_n_r + 1'b1; state_r <= S_FF0; end
        S_AGR: begin
          if (gres_r == 32'd0) begin
            status_r <= ST_OOM;
            state_r  <= S_DONE;
          end else begin
            tk_bp_r <= gres_r;
            state_r <= S_T0;
          end
        end
        S_T0: state_r <= S_T1;
        S_T1: begin
          cs_r     <= rd_sz;
          split_r  <= (rd_sz - 32'(need_r)) >= MIN_BLOCK;
          ul_x_r   <= tk_bp_r;
          ul_ret_r <= S_T2;
          state_r  <= S_UL0;
        end
        S_T2: state_r <= split_r ? S_T3 : S_T4;
        S_T3: begin
          lk_x_r   <= tk_bp_r + 32'(need_r);
          lk_ret_r <= S_TOK;
          state_r  <= S_LK0;
        end
        S_T4: begin aft_r <= tk_bp_r + rd_sz; state_r <= S_T5; end
        S_T5: state_r <= S_TOK;
        S_TOK: begin addr_r <= tk_bp_r[15:0]; state_r <= S_DONE; end
        S_REL0: state_r <= S_REL1;
        S_REL1: begin sz_r <= rd_sz; state_r <= S_REL2; end
        S_REL2: state_r <= S_REL3;
        S_REL3: state_r <= S_REL4;
        S_REL4: begin aft_r <= ptr_r + rd_sz; state_r <= S_REL5; end
        S_REL5: begin
          if (sz_r >= MIN_BLOCK) begin
            lk_x_r   <= ptr_r;
            lk_ret_r <= S_REL6;
            state_r  <= S_LK0;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_REL6: begin mg_bp_r <= ptr_r; mg_ret_r <= S_DONE; state_r <= S_M0; end
        S_G0: begin
          if (32'(brk_r) + g_sz32 > HEAP_LIM) begin
            gres_r  <= '0;
            state_r <= gr_ret_r;
          end else begin
            g_bp_r  <= 32'(brk_r);
            brk_r   <= BRK_W'(32'(brk_r) + g_sz32);
            state_r <= S_G1;
          end
        end
        S_G1: state_r <= S_G2;
        S_G2: state_r <= S_G3;
        S_G3: state_r <= S_G4;
        S_G4: state_r <= S_G5;
        S_G5: begin lk_x_r <= g_bp_r; lk_ret_r <= S_G6; state_r <= S_LK0; end
        S_G6: begin mg_bp_r <= g_bp_r; mg_ret_r <= S_G7; state_r <= S_M0; end
        S_G7: begin gres_r <= mres_r; state_r <= gr_ret_r; end
        S_LK0: state_r <= (lk_x_r == 32'd0) ? lk_ret_r : S_LK1;
        S_LK1: state_r <= S_LK2;
        S_LK2: begin head_r <= lk_x_r; state_r <= lk_ret_r; end
        S_UL0: state_r <= (ul_x_r == 32'd0) ? ul_ret_r : S_UL1;
        S_UL1: begin nx_r <= mem_rdata; state_r <= S_UL2; end
        S_UL2: begin pv_r <= mem_rdata; state_r <= S_UL3; end
        S_UL3: begin
          if (pv_r == 32'd0) begin
            head_r <= nx_r;
          end
          state_r <= ul_ret_r;
        end
        S_M0: state_r <= S_M1;
        S_M1: begin
          hsz_r   <= rd_sz;
          mpa_r   <= mem_rdata[1];
          aft_r   <= mg_bp_r + rd_sz;
          state_r <= S_M2;
        end
        S_M2: begin
          na_r  <= mem_rdata[0];
          nsz_r <= rd_sz;
          if (mpa_r && mem_rdata[0]) begin
            mres_r  <= mg_bp_r;
            state_r <= mg_ret_r;
          end else if (mpa_r) begin
            msz_r    <= hsz_r + rd_sz;
            ul_x_r   <= aft_r;
            ul_ret_r <= S_MP1;
            state_r  <= S_UL0;
          end else begin
            state_r <= S_M3;
          end
        end
        S_MP1: state_r <= S_MP2;
        S_MP2: begin mres_r <= mg_bp_r; state_r <= mg_ret_r; end
        S_M3: begin bef_r <= mg_bp_r - rd_sz; state_r <= S_M4; end
        S_M4: begin
          pp_r <= mem_rdata[1];
          if (na_r) begin
            msz_r   <= hsz_r + rd_sz;
            state_r <= S_M5;
          end else begin
            msz_r   <= hsz_r + rd_sz + nsz_r;
            state_r <= S_MA1;
          end
        end
        S_M5: state_r <= S_M6;
        S_M6: begin ul_x_r <= mg_bp_r; ul_ret_r <= S_MB0; state_r <= S_UL0; end
        S_MA1: state_r <= S_MA2;
        S_MA2: begin aft_r <= mg_bp_r + rd_sz; state_r <= S_MA3; end
        S_MA3: begin ul_x_r <= mg_bp_r; ul_ret_r <= S_MA4; state_r <= S_UL0; end
        S_MA4: state_r <= S_MA5;
        S_MA5: begin
          ul_x_r   <= mg_bp_r + rd_sz;
          ul_ret_r <= S_MB0;
          state_r  <= S_UL0;
        end
        S_MB0: state_r <= S_MB1;
        S_MB1: begin mres_r <= mg_bp_r - rd_sz; state_r <= mg_ret_r; end
        S_DONE: begin
          if (res_take) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[hdl/explicit_free_list_heap_allocator_unit.sv]
// Top level of the free list heap allocator: sequencer, heap RAM, result register.
// Depends on efla_pkg, efla_ram and efla_seq.
//
//   channel  direction  ports                                  transfer when
//   in       input      in_op, in_request_bytes, in_release_addr  in_valid & in_ready
//   out      output     out_block_addr, out_status              out_valid & out_ready
//
// One item at a time; every heap access goes through a single RAM port with
// registered read data. A null release returns ST_NULL, and a release of a block
// below the minimum is not linked into the free list. An allocate walks the free
// list first fit and grows the heap when no node fits, building it on first use.
// No clearing pass: the heap is built on first allocate.
// Reset is synchronous and active low. A result waiting in the output register
// does not block the next transfer in.
`timescale 1ns / 1ps
module explicit_free_list_heap_allocator_unit import efla_pkg::*; #(
  parameter int HEAP_BYTES = 65536,
  parameter int GROW_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [15:0] in_request_bytes,
  input  logic [15:0] in_release_addr,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_block_addr,
  output logic [1:0]  out_status
);

  localparam int MEM_WORDS = HEAP_BYTES / 4;
  localparam int AW        = $clog2(MEM_WORDS);

  res_t          res;
  logic          res_take;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [31:0]   mem_wdata, mem_rdata;
  logic          out_valid_r;
  logic [15:0]   out_addr_r;
  logic [1:0]    out_status_r;

  efla_seq #(.HEAP_BYTES(HEAP_BYTES), .GROW_BYTES(GROW_BYTES)) u_seq (
    .clk, .rst_n, .in_valid, .in_ready, .in_op, .in_request_bytes, .in_release_addr,
    .res, .res_take, .mem_we, .mem_addr, .mem_wdata, .mem_rdata
  );

  efla_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_heap (
    .clk, .we(mem_we), .addr(mem_addr), .wdata(mem_wdata), .rdata(mem_rdata)
  );

  assign res_take = !out_valid_r || out_ready;

  // hold the result until the consumer takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= res.valid;
      if (res.valid) begin
        out_addr_r   <= res.block_addr;
        out_status_r <= res.status;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_block_addr = out_addr_r;
  assign out_status     = out_status_r;

`ifndef ASSERT_OFF
  a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_block_addr == 16'd0)
    else $error("failed request carries a block address");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("sequencer ready right after a transfer in");

  a_done_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> !in_ready)
    else $error("result pending while sequencer idle");

  a_load_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid && res_take |=> out_valid)
    else $error("finished result not loaded into output register");
`endif

endmodule
